/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on clk_i and quiet in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising clock edge outside reset.
`define NPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must never be seen outside reset.
`define NPS_NEVER(lbl, cond, msg) \
  `NPS_ASSERT(lbl, !(cond), msg)

`endif

/* rtl/nps_pkg.sv */
// ---------------------------------------------------------------------------
// Nine-point stencil residual package
// Payload types, fixed widths and register indexes shared by the block.
// ---------------------------------------------------------------------------
package nps_pkg;

  localparam int VALUE_BITS = 32;
  localparam int PROD_W     = 2 * VALUE_BITS;
  // Nine products and the shifted right-hand side need four guard bits.
  localparam int ACC_W      = (2 * VALUE_BITS + 4 > 128) ? 128 : 2 * VALUE_BITS + 4;
  localparam int NBR_CNT    = 9;
  localparam int MAC_STAGES = 5;

  localparam int CFG_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int ROW_W      = 10;
  localparam int ROW_LIMIT  = 1024;
  localparam int GRID_MIN   = 3;

  localparam int FIFO_DEPTH = 16;
  localparam int FIFO_AW    = 4;
  localparam int CRED_W     = 5;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 2'd1;

  typedef logic signed [VALUE_BITS-1:0] nps_val_t;
  typedef nps_val_t [NBR_CNT-1:0] nps_vec_t;

  typedef struct packed {
    logic signed [31:0] x_value;
    logic signed [31:0] rhs_value;
    logic signed [31:0] coef_center;
    logic signed [31:0] coef_west;
    logic signed [31:0] coef_east;
    logic signed [31:0] coef_south;
    logic signed [31:0] coef_north;
    logic signed [31:0] coef_southwest;
    logic signed [31:0] coef_southeast;
    logic signed [31:0] coef_northwest;
    logic signed [31:0] coef_northeast;
  } nps_in_t;

  typedef struct packed {
    logic signed [31:0] residual_value;
    logic               last_result;
  } nps_out_t;

  // Control that travels alongside a request through the arithmetic pipeline.
  typedef struct packed {
    logic valid;
    logic last;
  } nps_tag_t;

endpackage

/* rtl/nps_mac.sv */
// ---------------------------------------------------------------------------
// Stencil multiply-accumulate pipeline
// Nine products, a registered adder tree, shift and saturation; five stages.
// ---------------------------------------------------------------------------
module nps_mac import nps_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  nps_tag_t tag_i,
  input  nps_vec_t x_nbr_i,
  input  nps_vec_t coef_i,
  input  nps_val_t rhs_i,
  output nps_tag_t tag_o,
  output nps_out_t res_o
);

  logic signed [PROD_W-1:0] prod_q [NBR_CNT];
  logic signed [ACC_W-1:0]  bterm_q;
  logic signed [ACC_W-1:0]  sum2_q [5];
  logic signed [ACC_W-1:0]  sum3_q [3];
  logic signed [ACC_W-1:0]  sum4_q;
  logic signed [ACC_W-1:0]  shifted;
  logic [ACC_W-VALUE_BITS:0] top_bits;
  logic                      fits;
  nps_out_t                  res_d;
  nps_out_t                  res_q;
  nps_tag_t                  tag_q [MAC_STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < MAC_STAGES; s++) begin
        tag_q[s] <= '0;
      end
    end else begin
      tag_q[0] <= tag_i;
      for (int s = 1; s < MAC_STAGES; s++) begin
        tag_q[s] <= tag_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NBR_CNT; k++) begin
      prod_q[k] <= PROD_W'(coef_i[k]) * PROD_W'(x_nbr_i[k]);
    end
    bterm_q <= ACC_W'(rhs_i) <<< FRACTION_BITS;

    // The centre term is subtracted; the eight neighbours are added in pairs.
    sum2_q[0] <= bterm_q - ACC_W'(prod_q[0]);
    for (int j = 1; j < 5; j++) begin
      sum2_q[j] <= ACC_W'(prod_q[2*j-1]) + ACC_W'(prod_q[2*j]);
    end

    sum3_q[0] <= sum2_q[0] + sum2_q[1];
    sum3_q[1] <= sum2_q[2] + sum2_q[3];
    sum3_q[2] <= sum2_q[4];

    sum4_q <= sum3_q[0] + sum3_q[1] + sum3_q[2];
    res_q  <= res_d;
  end

  always_comb begin
    shifted  = sum4_q >>> FRACTION_BITS;
    top_bits = shifted[ACC_W-1:VALUE_BITS-1];
    fits     = (&top_bits) | ~(|top_bits);
    res_d.last_result = tag_q[MAC_STAGES-2].last;
    if (fits) begin
      res_d.residual_value = shifted[VALUE_BITS-1:0];
    end else if (shifted[ACC_W-1]) begin
      res_d.residual_value = {1'b1, {(VALUE_BITS-1){1'b0}}};
    end else begin
      res_d.residual_value = {1'b0, {(VALUE_BITS-1){1'b1}}};
    end
  end

  assign tag_o = tag_q[MAC_STAGES-1];
  assign res_o = res_q;

endmodule

/* rtl/nine_point_stencil_residual_top.sv */
// ---------------------------------------------------------------------------
// Nine-point stencil residual
// Streams a padded grid and returns the saturated Q16.16 residual per point.
// ---------------------------------------------------------------------------
// The input channel takes one request per grid value in raster order, ghost
// ring included; each request also carries b and the nine coefficients of the
// interior point one row up and one column left. A request is taken at a
// clock edge where in_valid_i is high and in_stall_o is low. The output
// channel returns one residual for every request whose raster position has
// column and row both at least two, with last_result set for the final
// interior point of the frame; it is taken where out_valid_o is high and
// out_stall_i is low. A new request is accepted every cycle while in_stall_o
// is low. Each residual passes the line store read, the window update and
// the arithmetic pipeline, then waits in a sixteen-entry queue; in_stall_o
// rises only when sixteen results are outstanding, so a receiver that stalls
// for long enough halts the input without losing anything. Reset clears the
// queue and the raster position, loads grid_rows with its largest value and
// grid_columns with MAX_COLUMNS capped at 1024; the line store contents are
// undefined until a frame has streamed. A write to grid_columns or grid_rows
// restarts the frame at the first column of the first row.
// ---------------------------------------------------------------------------
module nine_point_stencil_residual_top import nps_pkg::*; #(
  parameter int MAX_COLUMNS   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  nps_in_t              in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output nps_out_t             out_data_o
);

`include "assert_macros.svh"

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int GC_W      = $clog2(MAX_COLUMNS + 1);
  localparam int CMP_W     = (GC_W > CFG_W) ? GC_W : CFG_W;
  localparam int GC_RESET  = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;

  // Configuration and raster position.
  logic [GC_W-1:0]  grid_cols_q;
  logic [CFG_W-1:0] grid_rows_q;
  logic [COL_W-1:0] col_q;
  logic [ROW_W-1:0] row_q;
  logic [CMP_W-1:0] cfg_wide;
  logic [GC_W-1:0]  cols_clamped;
  logic [CFG_W-1:0] rows_clamped;
  logic             in_accept;
  logic             emit_now;
  logic             col_wrap;
  logic             row_wrap;

  // Line store: each entry holds {two rows up, one row up} for one column.
  logic [2*VALUE_BITS-1:0] line_mem [MAX_COLUMNS];
  logic [2*VALUE_BITS-1:0] line_rd_q;

  // Request stage aligned with the line store read.
  logic             pa_valid_q;
  logic             pa_emit_q;
  logic             pa_last_q;
  logic [COL_W-1:0] pa_col_q;
  nps_in_t          pa_q;

  // 3x3 window: row 0 is two rows up, column 2 is the newest column.
  nps_val_t         win_q [3][3];
  nps_tag_t         pw_tag_q;
  nps_in_t          pw_q;
  nps_vec_t         x_nbr;
  nps_vec_t         coef;

  nps_tag_t         mac_tag;
  nps_out_t         mac_res;

  // Result queue and credit count.
  nps_out_t           fifo_mem [FIFO_DEPTH];
  logic [FIFO_AW:0]   wr_ptr_q;
  logic [FIFO_AW:0]   rd_ptr_q;
  logic [FIFO_AW:0]   fifo_count;
  logic [CRED_W-1:0]  credit_q;
  logic               out_accept;

  assign in_stall_o = (credit_q == CRED_W'(FIFO_DEPTH));
  assign in_accept  = in_valid_i && !in_stall_o;
  assign emit_now   = (col_q >= COL_W'(2)) && (row_q >= ROW_W'(2));
  assign col_wrap   = (GC_W'(col_q) + GC_W'(1)) >= grid_cols_q;
  assign row_wrap   = (CFG_W'(row_q) + CFG_W'(1)) >= grid_rows_q;

  // Register values are clamped to the legal grid size on the way in.
  always_comb begin
    cfg_wide = CMP_W'(cfg_data_i);
    if (cfg_wide < CMP_W'(GRID_MIN)) begin
      cols_clamped = GC_W'(GRID_MIN);
    end else if (cfg_wide > CMP_W'(MAX_COLUMNS)) begin
      cols_clamped = GC_W'(MAX_COLUMNS);
    end else begin
      cols_clamped = GC_W'(cfg_wide);
    end
    if (cfg_data_i < CFG_W'(GRID_MIN)) begin
      rows_clamped = CFG_W'(GRID_MIN);
    end else if (cfg_data_i > CFG_W'(ROW_LIMIT)) begin
      rows_clamped = CFG_W'(ROW_LIMIT);
    end else begin
      rows_clamped = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_cols_q <= GC_W'(GC_RESET);
      grid_rows_q <= CFG_W'(ROW_LIMIT);
      col_q       <= '0;
      row_q       <= '0;
      pa_valid_q  <= 1'b0;
      pw_tag_q    <= '0;
    end else begin
      pa_valid_q     <= in_accept;
      pw_tag_q.valid <= pa_valid_q && pa_emit_q;
      pw_tag_q.last  <= pa_last_q;
      if (cfg_we_i && (cfg_index_i == REG_GRID_COLUMNS || cfg_index_i == REG_GRID_ROWS)) begin
        if (cfg_index_i == REG_GRID_COLUMNS) begin
          grid_cols_q <= cols_clamped;
        end else begin
          grid_rows_q <= rows_clamped;
        end
        col_q <= '0;
        row_q <= '0;
      end else if (in_accept) begin
        if (col_wrap) begin
          col_q <= '0;
          row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
        end else begin
          col_q <= col_q + COL_W'(1);
        end
      end
    end
  end

  // The entry of the current column is read every cycle; the read taken at
  // the accepting edge is written back, shifted by one row, the cycle after.
  // Unless a register write restarts the frame, the same column is next read
  // at least three requests later, so the write has always landed by then.
  always_ff @(posedge clk_i) begin
    line_rd_q <= line_mem[col_q];
    if (pa_valid_q) begin
      line_mem[pa_col_q] <= {line_rd_q[VALUE_BITS-1:0], pa_q.x_value};
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pa_q      <= in_data_i;
      pa_col_q  <= col_q;
      pa_emit_q <= emit_now;
      pa_last_q <= col_wrap && row_wrap;
    end
    if (pa_valid_q) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= line_rd_q[2*VALUE_BITS-1:VALUE_BITS];
      win_q[1][2] <= line_rd_q[VALUE_BITS-1:0];
      win_q[2][2] <= pa_q.x_value;
      pw_q        <= pa_q;
    end
  end

  // Neighbors in coefficient order: centre, west, east, south, north,
  // south-west, south-east, north-west, north-east.
  always_comb begin
    x_nbr[0] = win_q[1][1];
    x_nbr[1] = win_q[1][0];
    x_nbr[2] = win_q[1][2];
    x_nbr[3] = win_q[0][1];
    x_nbr[4] = win_q[2][1];
    x_nbr[5] = win_q[0][0];
    x_nbr[6] = win_q[0][2];
    x_nbr[7] = win_q[2][0];
    x_nbr[8] = win_q[2][2];
    coef[0]  = pw_q.coef_center;
    coef[1]  = pw_q.coef_west;
    coef[2]  = pw_q.coef_east;
    coef[3]  = pw_q.coef_south;
    coef[4]  = pw_q.coef_north;
    coef[5]  = pw_q.coef_southwest;
    coef[6]  = pw_q.coef_southeast;
    coef[7]  = pw_q.coef_northwest;
    coef[8]  = pw_q.coef_northeast;
  end

  nps_mac #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (pw_tag_q),
    .x_nbr_i (x_nbr),
    .coef_i  (coef),
    .rhs_i   (pw_q.rhs_value),
    .tag_o   (mac_tag),
    .res_o   (mac_res)
  );

  // Every result that will reach the queue holds a credit from the moment
  // its request is accepted, so the queue cannot overflow.
  assign fifo_count  = wr_ptr_q - rd_ptr_q;
  assign out_valid_o = (wr_ptr_q != rd_ptr_q);
  assign out_data_o  = fifo_mem[rd_ptr_q[FIFO_AW-1:0]];
  assign out_accept  = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      credit_q <= '0;
    end else begin
      if (mac_tag.valid) begin
        wr_ptr_q <= wr_ptr_q + (FIFO_AW + 1)'(1);
      end
      if (out_accept) begin
        rd_ptr_q <= rd_ptr_q + (FIFO_AW + 1)'(1);
      end
      if ((in_accept && emit_now) && !out_accept) begin
        credit_q <= credit_q + CRED_W'(1);
      end else if (!(in_accept && emit_now) && out_accept) begin
        credit_q <= credit_q - CRED_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mac_tag.valid) begin
      fifo_mem[wr_ptr_q[FIFO_AW-1:0]] <= mac_res;
    end
  end

  `NPS_ASSERT(a_fifo_room, mac_tag.valid |-> (fifo_count < (FIFO_AW + 1)'(FIFO_DEPTH)), "result queue overflow")
  `NPS_ASSERT(a_credit_covers, CRED_W'(fifo_count) <= credit_q, "queued results exceed credits")
  `NPS_ASSERT(a_col_in_grid, GC_W'(col_q) < grid_cols_q, "column position beyond grid")
  `NPS_NEVER(a_out_without_credit, out_valid_o && (credit_q == '0), "result shown without credit")

endmodule
